// ===== src/arpc_pkg.sv =====
package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 512;
    localparam int QUEUE_DEPTH       = 2;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic [IP_W-1:0]  BCAST_IP  = '1;
    localparam logic [MAC_W-1:0] BCAST_MAC = '1;

    // input kinds
    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_SEND   = 2'd2;

    // arp operations in received packets
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

    // result kinds
    localparam logic [1:0] RK_REPLY   = 2'd0;
    localparam logic [1:0] RK_REQUEST = 2'd1;
    localparam logic [1:0] RK_LOOKUP  = 2'd2;

    // arp operations in emitted frames
    localparam logic [1:0] FRAME_OP_NONE    = 2'd0;
    localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
    localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

    // register select, from paddr[3]
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    typedef enum logic [1:0] {
        OP_REPLY,
        OP_INSERT,
        OP_LOOKUP,
        OP_SEND
    } arpc_op_t;

    typedef struct packed {
        arpc_op_t             op;
        logic [MAC_W-1:0]     mac;
        logic [IP_W-1:0]      key;
    } arpc_item_t;

    typedef struct packed {
        logic                 valid;
        arpc_item_t           item;
    } arpc_qhead_t;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [MAC_W-1:0]     eth_dest_mac;
        logic [1:0]           arp_opcode;
        logic [MAC_W-1:0]     frame_target_mac;
        logic [IP_W-1:0]      frame_target_ip;
        logic                 hit;
        logic [MAC_W-1:0]     found_mac;
        logic                 last;
    } arpc_result_t;

endpackage

// ===== src/arpc_ram.sv =====
module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/arpc_front.sv =====
module arpc_front
    import arpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [15:0]       opcode,
    input  logic [MAC_W-1:0]  sender_mac,
    input  logic [IP_W-1:0]   sender_ip,
    input  logic [IP_W-1:0]   target_ip,
    input  logic [IP_W-1:0]   own_ip,
    input  logic              pop,
    output logic              busy,
    output arpc_qhead_t       head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    arpc_item_t       q_item_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic       accept;
    logic       push;
    arpc_item_t push_item;

    assign busy   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;

    // classify: drop what causes nothing, tag the rest for the back end
    always_comb
    begin
        push      = 1'b0;
        push_item = '{op: OP_LOOKUP, mac: sender_mac, key: target_ip};
        if (accept)
        begin
            unique case (kind)
                KIND_PACKET:
                begin
                    priority if (opcode == ARP_OP_REQUEST)
                    begin
                        if (target_ip == own_ip)
                        begin
                            push          = 1'b1;
                            push_item.op  = OP_REPLY;
                            push_item.key = sender_ip;
                        end
                    end
                    else if (opcode == ARP_OP_REPLY)
                    begin
                        push          = 1'b1;
                        push_item.op  = OP_INSERT;
                        push_item.key = sender_ip;
                    end
                    else
                    begin
                        push = 1'b0;
                    end
                end
                KIND_LOOKUP:
                begin
                    push         = 1'b1;
                    push_item.op = OP_LOOKUP;
                end
                KIND_SEND:
                begin
                    push         = 1'b1;
                    push_item.op = OP_SEND;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = CNT_W'(count_reg + CNT_W'(1));
            2'b01:   count_next = CNT_W'(count_reg - CNT_W'(1));
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_item_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_item_reg[rd_ptr_reg];

endmodule

// ===== src/arpc_back.sv =====
module arpc_back
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  arpc_qhead_t  head,
    output logic         pop,
    output logic         done,
    output arpc_result_t result
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REQ
    } state_t;

    state_t           state_reg, state_next;
    arpc_item_t       item_reg, item_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             rd_zero_reg, rd_zero_next;
    logic [IDX_W-1:0] next_slot_reg, next_slot_next;
    logic [CNT_W-1:0] valid_count_reg, valid_count_next;
    logic             done_reg, done_next;
    arpc_result_t     result_reg, result_next;

    logic             issue;
    logic [IP_W-1:0]  ip_rdata;
    logic [MAC_W-1:0] mac_rdata;
    logic [IP_W-1:0]  cmp_ip;
    logic [MAC_W-1:0] cmp_mac;
    logic             match;
    logic             miss_done;
    logic             wr_en;

    assign issue = (state_reg == S_SCAN) && (addr_reg < valid_count_reg);

    arpc_ram #(.WIDTH(IP_W), .DEPTH(CACHE_ENTRIES)) u_ip_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (next_slot_reg),
        .wr_data (item_reg.key),
        .rd_en   (issue),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (ip_rdata)
    );

    arpc_ram #(.WIDTH(MAC_W), .DEPTH(CACHE_ENTRIES)) u_mac_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (next_slot_reg),
        .wr_data (item_reg.mac),
        .rd_en   (issue),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (mac_rdata)
    );

    // entry 0 is the fixed broadcast entry, never stored in the rams
    assign cmp_ip    = rd_zero_reg ? BCAST_IP  : ip_rdata;
    assign cmp_mac   = rd_zero_reg ? BCAST_MAC : mac_rdata;
    assign match     = rd_vld_reg && (cmp_ip == item_reg.key);
    assign miss_done = !issue && !rd_vld_reg;
    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign wr_en     = (state_reg == S_SCAN) && !match && miss_done
                       && (item_reg.op == OP_INSERT);

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        addr_next        = issue ? CNT_W'(addr_reg + CNT_W'(1)) : addr_reg;
        rd_vld_next      = issue;
        rd_zero_next     = issue && (addr_reg == '0);
        next_slot_next   = next_slot_reg;
        valid_count_next = valid_count_reg;
        done_next        = 1'b0;
        result_next      = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    item_next = head.item;
                    addr_next = '0;
                    if (head.item.op == OP_SEND)
                    begin
                        done_next                    = 1'b1;
                        result_next                  = '0;
                        result_next.result_kind      = RK_REQUEST;
                        result_next.eth_dest_mac     = BCAST_MAC;
                        result_next.arp_opcode       = FRAME_OP_REQUEST;
                        result_next.frame_target_ip  = head.item.key;
                        result_next.last             = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (match || miss_done)
                begin
                    state_next = S_IDLE;
                    unique case (item_reg.op)
                        OP_REPLY:
                        begin
                            done_next                     = 1'b1;
                            result_next                   = '0;
                            result_next.result_kind       = RK_REPLY;
                            result_next.eth_dest_mac      = item_reg.mac;
                            result_next.arp_opcode        = FRAME_OP_REPLY;
                            result_next.frame_target_mac  = item_reg.mac;
                            result_next.frame_target_ip   = item_reg.key;
                            result_next.last              = match;
                            if (!match)
                            begin
                                state_next = S_REQ;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            done_next               = 1'b1;
                            result_next             = '0;
                            result_next.result_kind = RK_LOOKUP;
                            result_next.hit         = match;
                            result_next.found_mac   = match ? cmp_mac : '0;
                            result_next.last        = 1'b1;
                        end
                        OP_INSERT:
                        begin
                            if (!match)
                            begin
                                next_slot_next =
                                    (next_slot_reg == IDX_W'(CACHE_ENTRIES - 1)) ?
                                    IDX_W'(1) : IDX_W'(next_slot_reg + IDX_W'(1));
                                if (valid_count_reg != CNT_W'(CACHE_ENTRIES))
                                begin
                                    valid_count_next = CNT_W'(valid_count_reg + CNT_W'(1));
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REQ:
            begin
                state_next                   = S_IDLE;
                done_next                    = 1'b1;
                result_next                  = '0;
                result_next.result_kind      = RK_REQUEST;
                result_next.eth_dest_mac     = BCAST_MAC;
                result_next.arp_opcode       = FRAME_OP_REQUEST;
                result_next.frame_target_ip  = item_reg.key;
                result_next.last             = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            addr_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            rd_zero_reg     <= 1'b0;
            next_slot_reg   <= IDX_W'(1);
            valid_count_reg <= CNT_W'(1);
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            item_reg        <= item_next;
            addr_reg        <= addr_next;
            rd_vld_reg      <= rd_vld_next;
            rd_zero_reg     <= rd_zero_next;
            next_slot_reg   <= next_slot_next;
            valid_count_reg <= valid_count_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/arp_responder_with_cache_core.sv =====
// arp responder with an ipv4-to-mac address cache
// command channel: an item transfers at a rising edge with start high and busy
// low; kind selects a received arp packet, a cache lookup or a send request
// config: apb-style port, own_ip at byte address 0, own_mac at byte address 8,
// 64-bit data, pready tied high; write only while the block is idle
// results: one cycle on the result ports marked by done, transferred at the
// edge that ends that cycle; the receiver cannot stall, so results never wait
// a lookup, an insert or a request aimed at us scans the cache one
// entry per cycle through the single read port of the cache memories;
// a hit ends the scan, a miss reads all valid entries (at most
// CACHE_ENTRIES, the broadcast entry included); a send request needs no
// scan and gives its result straight from idle; the scan engine takes
// a new item from the queue only once it is through with the last one,
// the follow-up request included
// a request to us whose sender is not cached gives a reply, then the
// broadcast request in the very next cycle (last low on the first)
// a two-entry queue between the classifier and the scan engine takes items
// while a scan runs; busy is high while that queue is full
// reset: queue empty, valid count 1 (only the broadcast entry), next slot 1,
// own_ip and own_mac zero; entry 0 is fixed and needs no clearing pass
module arp_responder_with_cache_core
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [15:0]        opcode,
    input  logic [MAC_W-1:0]   sender_mac,
    input  logic [IP_W-1:0]    sender_ip,
    input  logic [IP_W-1:0]    target_ip,
    // result channel
    output logic               done,
    output logic [1:0]         result_kind,
    output logic [MAC_W-1:0]   eth_dest_mac,
    output logic [1:0]         arp_opcode,
    output logic [MAC_W-1:0]   frame_target_mac,
    output logic [IP_W-1:0]    frame_target_ip,
    output logic               hit,
    output logic [MAC_W-1:0]   found_mac,
    output logic               last
);

    logic [IP_W-1:0]  own_ip_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic             cfg_wr;

    arpc_qhead_t      head;
    logic             pop;
    arpc_result_t     result;

    // register write transfer on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                REG_OWN_IP:  own_ip_reg  <= pwdata[IP_W-1:0];
                REG_OWN_MAC: own_mac_reg <= pwdata[MAC_W-1:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_OWN_IP:  prdata = PDATA_W'(own_ip_reg);
            REG_OWN_MAC: prdata = PDATA_W'(own_mac_reg);
            default:     prdata = '0;
        endcase
    end

    // front: takes and classifies commands, queues the ones with work to do
    arpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .opcode     (opcode),
        .sender_mac (sender_mac),
        .sender_ip  (sender_ip),
        .target_ip  (target_ip),
        .own_ip     (own_ip_reg),
        .pop        (pop),
        .busy       (busy),
        .head       (head)
    );

    // back: cache scan, insertion and result framing
    arpc_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

    assign result_kind      = result.result_kind;
    assign eth_dest_mac     = result.eth_dest_mac;
    assign arp_opcode       = result.arp_opcode;
    assign frame_target_mac = result.frame_target_mac;
    assign frame_target_ip  = result.frame_target_ip;
    assign hit              = result.hit;
    assign found_mac        = result.found_mac;
    assign last             = result.last;

endmodule

// ===== src/arpc_checker.sv =====
module arpc_checker
    import arpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             done,
    input  logic [1:0]       result_kind,
    input  logic [MAC_W-1:0] eth_dest_mac,
    input  logic [1:0]       arp_opcode,
    input  logic [MAC_W-1:0] frame_target_mac,
    input  logic             last
);

    // a reply without last is followed at once by the broadcast request
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && last && (result_kind == RK_REQUEST))
        else $error("second result of a reply pair missing");

    // only replies may come without last
    a_only_reply_open: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> (result_kind == RK_REPLY))
        else $error("open result that is not a reply");

    a_request_frame: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result_kind == RK_REQUEST) |->
        (eth_dest_mac == BCAST_MAC) && (frame_target_mac == '0)
        && (arp_opcode == FRAME_OP_REQUEST))
        else $error("malformed request frame");

    a_reply_frame: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result_kind == RK_REPLY) |->
        (eth_dest_mac == frame_target_mac) && (arp_opcode == FRAME_OP_REPLY))
        else $error("malformed reply frame");

endmodule

bind arp_responder_with_cache_core arpc_checker u_arpc_checker (.*);
